/* rtl/i2cmts_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Shared types, opcodes, status codes, register indexes and helpers.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 16;
    localparam int POS_W                = 5;
    localparam int IDX9_W               = 9;
    localparam int APB_AW               = 4;
    localparam int APB_DW               = 32;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] REG_SLAVE_ADDRESS   = 2'd0;
    localparam logic [1:0] REG_TRANSFER_MODE   = 2'd1;
    localparam logic [1:0] REG_TRANSFER_LENGTH = 2'd2;

    localparam logic MODE_WRITE = 1'b0;

    localparam logic [7:0] STAT_START_SENT   = 8'h08;
    localparam logic [7:0] STAT_RESTART_SENT = 8'h10;
    localparam logic [7:0] STAT_SLA_W_ACK    = 8'h18;
    localparam logic [7:0] STAT_SLA_W_NACK   = 8'h20;
    localparam logic [7:0] STAT_DATA_TX_ACK  = 8'h28;
    localparam logic [7:0] STAT_DATA_TX_NACK = 8'h30;
    localparam logic [7:0] STAT_SLA_R_ACK    = 8'h40;
    localparam logic [7:0] STAT_SLA_R_NACK   = 8'h48;
    localparam logic [7:0] STAT_DATA_RX_ACK  = 8'h50;
    localparam logic [7:0] STAT_DATA_RX_NACK = 8'h58;
    localparam logic [7:0] STAT_BUS_ERROR    = 8'hF8;

    localparam logic [POS_W-1:0] POS_MAX = 5'd31;

    typedef enum logic [1:0] {
        ACT_LEAVE = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_RD_WAIT,
        S_CHK0,
        S_CHK1,
        S_CHK2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        action_t    start_action;
        logic       stop_request;
        action_t    ack_action;
        logic       engine_reset;
        logic       read_ok;
        logic       fault;
        logic [7:0] read_data;
    } result_t;

    // Set acknowledge while more than one byte remains to be received.
    function automatic action_t ack_choice(input logic [POS_W-1:0] pos,
                                           input logic [POS_W-1:0] total);
        action_t act;
        act = ACT_CLEAR;
        if (total != '0 && pos < total - 5'd1) begin
            act = ACT_SET;
        end
        return act;
    endfunction

    function automatic logic [POS_W-1:0] pos_advance(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] nxt;
        nxt = pos;
        if (pos != POS_MAX) begin
            nxt = pos + 5'd1;
        end
        return nxt;
    endfunction

endpackage

/* rtl/i2c_master_transfer_sequencer.sv */
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Drives an I2C byte engine from its status codes: fills a transfer buffer,
// appends a checksum to writes and checks the first two bytes of reads.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  s_       | s_valid / s_ready  | opcode, byte_index, byte_value, bus_status,
//           |                    | received_byte
//  m_       | m_valid / m_ready  | send_valid, send_byte, start_action,
//           |                    | stop_request, ack_action, engine_reset,
//           |                    | read_ok, fault, read_data
//  APB      | psel/penable/pready| slave_address, transfer_mode, transfer_length
//
// One item at a time; s_ready is high only while the sequencer is idle.
// Buffer reads and data sends inside the buffer go through its registered read
// port; those past the buffer do not, and the final read status reads bytes 0
// and 1 back for its check. A write start runs the single buffer read port and
// the byte accumulator over the clamped length, at most min(31, BUFFER_DEPTH - 1).
// The finished result sits in the output register; the next item is taken
// while it waits, and a further result stalls in the done state until m_ready.
// Reset (aresetn low, synchronous) clears control, position, length and
// configuration; the buffer is not cleared and holds junk until written.
//
module i2c_master_transfer_sequencer #(
    parameter int BUFFER_DEPTH = i2cmts_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_opcode,
    input  logic [3:0]                    s_byte_index,
    input  logic [7:0]                    s_byte_value,
    input  logic [7:0]                    s_bus_status,
    input  logic [7:0]                    s_received_byte,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_send_valid,
    output logic [7:0]                    m_send_byte,
    output logic [1:0]                    m_start_action,
    output logic                          m_stop_request,
    output logic [1:0]                    m_ack_action,
    output logic                          m_engine_reset,
    output logic                          m_read_ok,
    output logic                          m_fault,
    output logic [7:0]                    m_read_data,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [i2cmts_pkg::APB_AW-1:0] paddr,
    input  logic [i2cmts_pkg::APB_DW-1:0] pwdata,
    output logic [i2cmts_pkg::APB_DW-1:0] prdata,
    output logic                          pready
);
    import i2cmts_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [IDX9_W-1:0] DEPTH9 = IDX9_W'(BUFFER_DEPTH);
    localparam logic [POS_W-1:0]  LEN_CLAMP = POS_W'(BUFFER_DEPTH - 1);

    // configuration
    logic [6:0]       slave_address_reg;
    logic             transfer_mode_reg;
    logic [POS_W-1:0] transfer_length_reg;

    // sequencer state
    state_t           state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] bytes_reg, bytes_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic [POS_W-1:0] cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       b0_reg, b0_next;
    result_t          res_reg, res_next;
    result_t          out_reg, out_next;
    logic             m_valid_reg, m_valid_next;

    // buffer port
    logic [7:0]    mem [BUFFER_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    rd_q;

    logic             cfg_write;
    logic             accept;
    logic             idx_in_range;
    logic             pos_in_range;
    logic [POS_W-1:0] len_clamped;
    logic [POS_W-1:0] pos_adv;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg   <= '0;
            transfer_mode_reg   <= 1'b0;
            transfer_length_reg <= '0;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_SLAVE_ADDRESS:   slave_address_reg   <= pwdata[6:0];
                REG_TRANSFER_MODE:   transfer_mode_reg   <= pwdata[0];
                REG_TRANSFER_LENGTH: transfer_length_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_SLAVE_ADDRESS:   prdata = APB_DW'(slave_address_reg);
            REG_TRANSFER_MODE:   prdata = APB_DW'(transfer_mode_reg);
            REG_TRANSFER_LENGTH: prdata = APB_DW'(transfer_length_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Transfer buffer: one write and one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_q <= mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign s_ready      = (state_reg == S_IDLE);
    assign accept       = s_valid && s_ready;
    assign idx_in_range = IDX9_W'(s_byte_index) < DEPTH9;
    assign pos_in_range = IDX9_W'(pos_reg) < DEPTH9;
    assign pos_adv      = pos_advance(pos_reg);

    // A write reserves the last buffer slot for its checksum.
    assign len_clamped = (IDX9_W'(transfer_length_reg) >= DEPTH9) ? LEN_CLAMP
                                                                   : transfer_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pos_reg     <= '0;
            bytes_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            bytes_reg   <= bytes_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        len_reg  <= len_next;
        cnt_reg  <= cnt_next;
        pend_reg <= pend_next;
        sum_reg  <= sum_next;
        b0_reg   <= b0_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        pos_next     = pos_reg;
        bytes_next   = bytes_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        sum_next     = sum_reg;
        b0_next      = b0_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;

        // drop the output item once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next    = s_opcode;
                    res_next   = '0;
                    state_next = S_DONE;
                    unique case (s_opcode)
                        OP_LOAD: begin
                            mem_we    = idx_in_range;
                            mem_waddr = AW'(s_byte_index);
                            mem_wdata = s_byte_value;
                        end
                        OP_START: begin
                            res_next.start_action = ACT_SET;
                            pos_next = '0;
                            if (transfer_mode_reg == MODE_WRITE) begin
                                len_next   = len_clamped;
                                cnt_next   = '0;
                                pend_next  = 1'b0;
                                sum_next   = '0;
                                state_next = S_SUM;
                            end else begin
                                bytes_next = transfer_length_reg;
                            end
                        end
                        OP_READ: begin
                            if (idx_in_range) begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(s_byte_index);
                                state_next = S_RD_WAIT;
                            end
                        end
                        default: begin
                            unique case (s_bus_status) inside
                                STAT_START_SENT, STAT_RESTART_SENT: begin
                                    res_next.send_valid = 1'b1;
                                    res_next.send_byte  = {slave_address_reg,
                                                           transfer_mode_reg};
                                end
                                STAT_SLA_W_ACK, STAT_DATA_TX_ACK: begin
                                    res_next.start_action = ACT_CLEAR;
                                    if (pos_reg < bytes_reg) begin
                                        res_next.send_valid = 1'b1;
                                        pos_next = pos_adv;
                                        if (pos_in_range) begin
                                            mem_re     = 1'b1;
                                            mem_raddr  = AW'(pos_reg);
                                            state_next = S_RD_WAIT;
                                        end
                                    end else begin
                                        res_next.stop_request = 1'b1;
                                        pos_next = '0;
                                    end
                                end
                                STAT_SLA_W_NACK, STAT_DATA_TX_NACK: begin
                                    res_next.start_action = ACT_CLEAR;
                                    res_next.stop_request = 1'b1;
                                    pos_next = '0;
                                end
                                STAT_SLA_R_ACK: begin
                                    res_next.start_action = ACT_CLEAR;
                                    res_next.ack_action   = ack_choice(pos_reg, bytes_reg);
                                end
                                STAT_SLA_R_NACK: begin
                                    res_next.start_action = ACT_SET;
                                    res_next.stop_request = 1'b1;
                                end
                                STAT_DATA_RX_ACK: begin
                                    mem_we    = pos_in_range;
                                    mem_waddr = AW'(pos_reg);
                                    mem_wdata = s_received_byte;
                                    pos_next  = pos_adv;
                                    res_next.ack_action = ack_choice(pos_adv, bytes_reg);
                                end
                                STAT_DATA_RX_NACK: begin
                                    mem_we    = pos_in_range;
                                    mem_waddr = AW'(pos_reg);
                                    mem_wdata = s_received_byte;
                                    pos_next  = '0;
                                    res_next.ack_action   = ACT_CLEAR;
                                    res_next.stop_request = 1'b1;
                                    state_next = S_CHK0;
                                end
                                default: begin
                                    // bus error or unknown code: recover the engine
                                    pos_next = '0;
                                    res_next.start_action = ACT_CLEAR;
                                    res_next.stop_request = 1'b1;
                                    res_next.engine_reset = 1'b1;
                                    res_next.fault        = 1'b1;
                                end
                            endcase
                        end
                    endcase
                end
            end

            // Checksum: stream buffer bytes through the accumulator, one a cycle.
            S_SUM: begin
                if (cnt_reg < len_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(cnt_reg);
                    cnt_next  = cnt_reg + 5'd1;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    sum_next = sum_reg + rd_q;
                end
                if (cnt_reg >= len_reg && !pend_reg) begin
                    mem_we     = 1'b1;
                    mem_waddr  = AW'(len_reg);
                    mem_wdata  = ~sum_reg;
                    bytes_next = len_reg + 5'd1;
                    state_next = S_DONE;
                end
            end

            S_RD_WAIT: begin
                if (op_reg == OP_READ) begin
                    res_next.read_data = rd_q;
                end else begin
                    res_next.send_byte = rd_q;
                end
                state_next = S_DONE;
            end

            // Read check: byte 1 must be the complement of byte 0.
            S_CHK0: begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = S_CHK1;
            end

            S_CHK1: begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(1);
                state_next = S_CHK2;
            end

            S_CHK2: begin
                if (rd_q == ~b0_reg) begin
                    res_next.read_ok = 1'b1;
                end else begin
                    res_next.fault = 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE: begin
                // hold the item until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // capture byte 0 as it comes out of the read port
        if (state_reg == S_CHK1) begin
            b0_next = rd_q;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_send_valid   = out_reg.send_valid;
    assign m_send_byte    = out_reg.send_byte;
    assign m_start_action = out_reg.start_action;
    assign m_stop_request = out_reg.stop_request;
    assign m_ack_action   = out_reg.ack_action;
    assign m_engine_reset = out_reg.engine_reset;
    assign m_read_ok      = out_reg.read_ok;
    assign m_fault        = out_reg.fault;
    assign m_read_data    = out_reg.read_data;

endmodule
